// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge while out of reset
`define QBT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// property checked on every rising clock edge, reset included
`define QBT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hdl/qbt_pkg.sv
// shared constants and types of the quadratic bezier tessellator
// no dependencies; used by every file of the block but the queue and the macros
package qbt_pkg;

    // default coordinate width (signed q2.14)
    localparam int COORD_BITS_DEF = 16;

    // segments register
    localparam int SEG_BITS = 6;
    localparam logic [SEG_BITS-1:0] SEG_RESET = 6'd32;

    // segments squared fits here (63 * 63 = 3969)
    localparam int DEN_BITS = 2 * SEG_BITS;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // coordinate slots carried by one command
    localparam int NUM_COORDS = 6;
    localparam int C_P0X = 0;
    localparam int C_P0Y = 1;
    localparam int C_P1X = 2;
    localparam int C_P1Y = 3;
    localparam int C_P2X = 4;
    localparam int C_P2Y = 5;

    typedef enum logic {
        CMD_SEG,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      emit_start;
        logic      fin;
    } cmd_ctl_t;

    localparam int CTL_BITS = $bits(cmd_ctl_t);

endpackage

// File: hdl/qbt_if.sv
// valid/ready channel interfaces of the tessellator
// depends on qbt_pkg

// control point word
interface qbt_point_if #(parameter int COORD_BITS = qbt_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         final_point;

    modport source (output valid, point_x, point_y, final_point, input ready);
    modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

// curve point word
interface qbt_curve_if #(parameter int COORD_BITS = qbt_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] curve_x;
    logic signed [COORD_BITS-1:0] curve_y;
    logic                         end_of_curve;
    logic                         bad_count;

    modport source (output valid, curve_x, curve_y, end_of_curve, bad_count, input ready);
    modport sink   (input valid, curve_x, curve_y, end_of_curve, bad_count, output ready);
endinterface

// segments register write
interface qbt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [qbt_pkg::SEG_BITS-1:0]  segments;

    modport source (output valid, segments, input ready);
    modport sink   (input valid, segments, output ready);
endinterface

// File: hdl/qbt_front.sv
// front end: tracks the chain phase and turns points into segment and error commands
// depends on qbt_pkg
module qbt_front #(
    parameter int COORD_BITS = qbt_pkg::COORD_BITS_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  logic signed [COORD_BITS-1:0]                       in_x,
    input  logic signed [COORD_BITS-1:0]                       in_y,
    input  logic                                               in_fin,
    output logic                                               push,
    output qbt_pkg::cmd_ctl_t                                  push_ctl,
    output logic [qbt_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]     push_coords,
    input  logic                                               queue_full
);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_HANDLE = 2'd1;
    localparam logic [1:0] PH_END    = 2'd2;

    logic [1:0]                   phase_reg, phase_next;
    logic                         started_reg, started_next;
    logic signed [COORD_BITS-1:0] anchor_x_reg, anchor_x_next;
    logic signed [COORD_BITS-1:0] anchor_y_reg, anchor_y_next;
    logic signed [COORD_BITS-1:0] handle_x_reg, handle_x_next;
    logic signed [COORD_BITS-1:0] handle_y_reg, handle_y_next;
    logic                         accept;

    // a word is taken whenever the queue has room
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // command payload: current segment plus the incoming end point
    always_comb
    begin
        push_coords                       = '0;
        push_coords[qbt_pkg::C_P0X]       = anchor_x_reg;
        push_coords[qbt_pkg::C_P0Y]       = anchor_y_reg;
        push_coords[qbt_pkg::C_P1X]       = handle_x_reg;
        push_coords[qbt_pkg::C_P1Y]       = handle_y_reg;
        push_coords[qbt_pkg::C_P2X]       = in_x;
        push_coords[qbt_pkg::C_P2Y]       = in_y;
    end

    // phase tracking
    always_comb
    begin
        phase_next          = phase_reg;
        started_next        = started_reg;
        anchor_x_next       = anchor_x_reg;
        anchor_y_next       = anchor_y_reg;
        handle_x_next       = handle_x_reg;
        handle_y_next       = handle_y_reg;
        push                = 1'b0;
        push_ctl.kind       = qbt_pkg::CMD_SEG;
        push_ctl.emit_start = !started_reg;
        push_ctl.fin        = in_fin;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    anchor_x_next = in_x;
                    anchor_y_next = in_y;
                    phase_next    = PH_HANDLE;
                end
                PH_HANDLE:
                begin
                    handle_x_next = in_x;
                    handle_y_next = in_y;
                    phase_next    = PH_END;
                end
                default:
                begin
                    // segment end, also the unreachable fourth code
                    push          = 1'b1;
                    anchor_x_next = in_x;
                    anchor_y_next = in_y;
                    phase_next    = PH_HANDLE;
                    started_next  = 1'b1;
                end
            endcase
            if (in_fin)
            begin
                phase_next   = PH_FIRST;
                started_next = 1'b0;
                if (phase_reg == PH_FIRST || phase_reg == PH_HANDLE)
                begin
                    push               = 1'b1;
                    push_ctl.kind      = qbt_pkg::CMD_ERR;
                    push_ctl.emit_start = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIRST;
            started_reg  <= 1'b0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            handle_x_reg <= '0;
            handle_y_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            started_reg  <= started_next;
            anchor_x_reg <= anchor_x_next;
            anchor_y_reg <= anchor_y_next;
            handle_x_reg <= handle_x_next;
            handle_y_reg <= handle_y_next;
        end
    end

endmodule

// File: hdl/qbt_queue.sv
// small command queue between front and back end
// depends on nothing but its parameters
module qbt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/qbt_div.sv
// restoring divider, one quotient bit per cycle, floor quotient and remainder
// depends on qbt_pkg
module qbt_div #(
    parameter int NUM_BITS = 24,
    parameter int QUO_BITS = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [NUM_BITS:0]          num,
    input  logic [qbt_pkg::DEN_BITS-1:0]      den,
    output logic                              busy,
    output logic signed [QUO_BITS-1:0]        quo,
    output logic [qbt_pkg::DEN_BITS-1:0]      rem
);

    localparam int DB = qbt_pkg::DEN_BITS;
    localparam int CW = $clog2(NUM_BITS + 1);

    logic              busy_reg, busy_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [DB-1:0]     den_reg, den_next;
    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [DB-1:0]     rem_reg, rem_next;
    logic [NUM_BITS:0] mag;
    logic [DB:0]       trial;
    logic [DB:0]       trial_sub;
    logic              ge;
    logic signed [NUM_BITS:0] qmag;
    logic signed [NUM_BITS:0] qsgn;
    logic              fix;

    assign mag       = num[NUM_BITS] ? -num : num;
    assign trial     = {rem_reg, acc_reg[NUM_BITS-1]};
    assign ge        = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    // one shift-subtract step a cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_BITS);
            neg_next  = num[NUM_BITS];
            den_next  = den;
            acc_next  = mag[NUM_BITS-1:0];
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = {acc_reg[NUM_BITS-2:0], ge};
            rem_next  = ge ? trial_sub[DB-1:0] : trial[DB-1:0];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    // floor result for a negative dividend
    assign fix  = neg_reg && (rem_reg != '0);
    assign qmag = $signed({1'b0, acc_reg});
    assign qsgn = neg_reg ? (fix ? -qmag - 2'sd1 : -qmag) : qmag;
    assign quo  = qsgn[QUO_BITS-1:0];
    assign rem  = fix ? den_reg - rem_reg : rem_reg;
    assign busy = busy_reg;

endmodule

// File: hdl/qbt_back.sv
// back end: per segment sets up difference terms with dividers,
// then steps the curve one point a cycle into the output register while that is free
// depends on qbt_pkg and qbt_div
module qbt_back #(
    parameter int COORD_BITS = qbt_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            cfg_we,
    input  logic [qbt_pkg::SEG_BITS-1:0]                    cfg_data,
    input  logic                                            q_empty,
    output logic                                            q_pop,
    input  qbt_pkg::cmd_ctl_t                               q_ctl,
    input  logic [qbt_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]  q_coords,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [COORD_BITS-1:0]                           out_x,
    output logic [COORD_BITS-1:0]                           out_y,
    output logic                                            out_eoc,
    output logic                                            out_bad
);

    localparam int C        = COORD_BITS;
    localparam int NUM_BITS = C + 8;
    localparam int QW       = C + 5;
    localparam int BW       = C + 3;
    localparam int DB       = qbt_pkg::DEN_BITS;
    localparam int SB       = qbt_pkg::SEG_BITS;
    localparam int SW       = QW + DB;

    localparam logic [QW-1:0] SAT_MAX = {{(QW - C + 1){1'b0}}, {(C - 1){1'b1}}};
    localparam logic [QW-1:0] SAT_MIN = {{(QW - C + 1){1'b1}}, {(C - 1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [SB-1:0] seg_reg, seg_next;
    logic [SB-1:0] n_reg, n_next;
    logic [DB-1:0] den_reg, den_next;
    logic          fin_reg, fin_next;
    logic          start_pend_reg, start_pend_next;
    logic [SB-1:0] jcnt_reg, jcnt_next;
    logic [qbt_pkg::NUM_COORDS-1:0][C-1:0] coords_reg, coords_next;

    logic [QW-1:0] val_q_reg [2];
    logic [QW-1:0] val_q_next [2];
    logic [DB-1:0] val_r_reg [2];
    logic [DB-1:0] val_r_next [2];
    logic [QW-1:0] d1_q_reg [2];
    logic [QW-1:0] d1_q_next [2];
    logic [DB-1:0] d1_r_reg [2];
    logic [DB-1:0] d1_r_next [2];
    logic [QW-1:0] d2_q_reg [2];
    logic [QW-1:0] d2_q_next [2];
    logic [DB-1:0] d2_r_reg [2];
    logic [DB-1:0] d2_r_next [2];

    logic          out_valid_reg, out_valid_next;
    logic [C-1:0]  out_x_reg, out_x_next;
    logic [C-1:0]  out_y_reg, out_y_next;
    logic          out_eoc_reg, out_eoc_next;
    logic          out_bad_reg, out_bad_next;

    logic [SB-1:0] n_eff;
    logic          slot_free;
    logic          div_start;
    logic [3:0]    div_busy;
    logic          last_pt;
    logic signed [SB+1:0] two_n_s;
    logic [QW-1:0] d1_quo [2];
    logic [DB-1:0] d1_rem [2];
    logic [QW-1:0] d2_quo [2];
    logic [DB-1:0] d2_rem [2];
    logic [SW-1:0] val_step [2];
    logic [SW-1:0] d1_step [2];
    logic [C-1:0]  pt [2];

    // add two values held as quotient and remainder over den
    function automatic logic [SW-1:0] nadd(
        input logic [QW-1:0] aq,
        input logic [DB-1:0] ar,
        input logic [QW-1:0] bq,
        input logic [DB-1:0] br,
        input logic [DB-1:0] den
    );
        logic [QW-1:0] sq;
        logic [DB:0]   sr;
        logic [DB:0]   sd;
        sq = aq + bq;
        sr = {1'b0, ar} + {1'b0, br};
        sd = sr - {1'b0, den};
        if (sr >= {1'b0, den})
        begin
            return {sq + QW'(1), sd[DB-1:0]};
        end
        return {sq, sr[DB-1:0]};
    endfunction

    // round to nearest, ties away from zero, then saturate
    function automatic logic [C-1:0] round_sat(
        input logic [QW-1:0] q,
        input logic [DB-1:0] r,
        input logic [DB-1:0] den
    );
        logic [DB-1:0] half;
        logic          up;
        logic [QW-1:0] rnd;
        half = den >> 1;
        up   = q[QW-1] ? (r > half) : (r >= den - half);
        rnd  = q + QW'(up);
        if ($signed(rnd) > $signed(SAT_MAX))
        begin
            rnd = SAT_MAX;
        end
        else if ($signed(rnd) < $signed(SAT_MIN))
        begin
            rnd = SAT_MIN;
        end
        return rnd[C-1:0];
    endfunction

    assign n_eff     = (seg_reg == '0) ? SB'(1) : seg_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign div_start = (state_reg == S_PREP);
    assign last_pt   = (jcnt_reg == n_reg - 1'b1);
    assign two_n_s   = $signed({1'b0, n_reg, 1'b0});

    // per axis: difference-term numerators and their dividers
    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        logic signed [C:0]          a_diff;
        logic signed [BW-1:0]       b_sum;
        logic signed [NUM_BITS:0]   prod;
        logic signed [NUM_BITS:0]   n1;
        logic signed [NUM_BITS:0]   n2;

        // first difference 2nA + B and second difference 2B
        assign a_diff = (C + 1)'($signed(coords_reg[qbt_pkg::C_P1X + a]))
                      - (C + 1)'($signed(coords_reg[qbt_pkg::C_P0X + a]));
        assign b_sum  = BW'($signed(coords_reg[qbt_pkg::C_P0X + a]))
                      - (BW'($signed(coords_reg[qbt_pkg::C_P1X + a])) <<< 1)
                      + BW'($signed(coords_reg[qbt_pkg::C_P2X + a]));
        assign prod   = a_diff * two_n_s;
        assign n1     = prod + (NUM_BITS + 1)'(b_sum);
        assign n2     = (NUM_BITS + 1)'(b_sum) <<< 1;

        qbt_div #(
            .NUM_BITS (NUM_BITS),
            .QUO_BITS (QW)
        ) u_div_d1 (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (n1),
            .den   (den_reg),
            .busy  (div_busy[2 * a]),
            .quo   (d1_quo[a]),
            .rem   (d1_rem[a])
        );

        qbt_div #(
            .NUM_BITS (NUM_BITS),
            .QUO_BITS (QW)
        ) u_div_d2 (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (n2),
            .den   (den_reg),
            .busy  (div_busy[2 * a + 1]),
            .quo   (d2_quo[a]),
            .rem   (d2_rem[a])
        );
    end

    // next curve point and next first difference
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            val_step[a] = nadd(val_q_reg[a], val_r_reg[a], d1_q_reg[a], d1_r_reg[a], den_reg);
            d1_step[a]  = nadd(d1_q_reg[a], d1_r_reg[a], d2_q_reg[a], d2_r_reg[a], den_reg);
            pt[a]       = round_sat(val_step[a][SW-1:DB], val_step[a][DB-1:0], den_reg);
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        seg_next        = seg_reg;
        n_next          = n_reg;
        den_next        = den_reg;
        fin_next        = fin_reg;
        start_pend_next = start_pend_reg;
        jcnt_next       = jcnt_reg;
        coords_next     = coords_reg;
        val_q_next      = val_q_reg;
        val_r_next      = val_r_reg;
        d1_q_next       = d1_q_reg;
        d1_r_next       = d1_r_reg;
        d2_q_next       = d2_q_reg;
        d2_r_next       = d2_r_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_eoc_next    = out_eoc_reg;
        out_bad_next    = out_bad_reg;
        q_pop           = 1'b0;

        if (cfg_we)
        begin
            seg_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    coords_next     = q_coords;
                    fin_next        = q_ctl.fin;
                    n_next          = n_eff;
                    den_next        = DB'(n_eff * n_eff);
                    start_pend_next = q_ctl.emit_start && (q_ctl.kind == qbt_pkg::CMD_SEG);
                    state_next      = (q_ctl.kind == qbt_pkg::CMD_ERR) ? S_ERR : S_PREP;
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    out_eoc_next   = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PREP:
            begin
                // dividers start this cycle; curve value starts at P0 exactly
                for (int a = 0; a < 2; a++)
                begin
                    val_q_next[a] = QW'($signed(coords_reg[qbt_pkg::C_P0X + a]));
                    val_r_next[a] = '0;
                end
                jcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_busy == '0)
                begin
                    d1_q_next  = d1_quo;
                    d1_r_next  = d1_rem;
                    d2_q_next  = d2_quo;
                    d2_r_next  = d2_rem;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!start_pend_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = pt[0];
                    out_y_next     = pt[1];
                    out_eoc_next   = fin_reg && last_pt;
                    out_bad_next   = 1'b0;
                    for (int a = 0; a < 2; a++)
                    begin
                        val_q_next[a] = val_step[a][SW-1:DB];
                        val_r_next[a] = val_step[a][DB-1:0];
                        d1_q_next[a]  = d1_step[a][SW-1:DB];
                        d1_r_next[a]  = d1_step[a][DB-1:0];
                    end
                    jcnt_next = jcnt_reg + 1'b1;
                    if (last_pt)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // chain start point goes out once the output is free, ahead of the first curve point
        if (start_pend_reg && slot_free
            && (state_reg == S_PREP || state_reg == S_DIV || state_reg == S_EMIT))
        begin
            start_pend_next = 1'b0;
            out_valid_next  = 1'b1;
            out_x_next      = coords_reg[qbt_pkg::C_P0X];
            out_y_next      = coords_reg[qbt_pkg::C_P0Y];
            out_eoc_next    = 1'b0;
            out_bad_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seg_reg        <= qbt_pkg::SEG_RESET;
            start_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seg_reg        <= seg_next;
            start_pend_reg <= start_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        den_reg     <= den_next;
        fin_reg     <= fin_next;
        jcnt_reg    <= jcnt_next;
        coords_reg  <= coords_next;
        val_q_reg   <= val_q_next;
        val_r_reg   <= val_r_next;
        d1_q_reg    <= d1_q_next;
        d1_r_reg    <= d1_r_next;
        d2_q_reg    <= d2_q_next;
        d2_r_reg    <= d2_r_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_eoc_reg <= out_eoc_next;
        out_bad_reg <= out_bad_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_eoc   = out_eoc_reg;
    assign out_bad   = out_bad_reg;

endmodule

// File: hdl/quadratic_bezier_tessellator_unit.sv
// A start or handle point is taken and gives nothing unless it ends the chain. With the back
// end idle, a segment end passes through the command queue into the setup state; a new chain's
// start point goes to the output register first, while the bit-serial dividers work if free;
// curve points follow from the stepper, one a cycle while the receiver takes them. A segment
// is taken only once the last is stepped out. A bad count gives its error word via the queue.
// Reset (async, active low) clears phase and control state and sets segments to 32.
module quadratic_bezier_tessellator_unit #(
    parameter int COORD_BITS = qbt_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    qbt_point_if.sink     point,
    qbt_curve_if.source   curve,
    qbt_cfg_if.sink       cfg
);

    localparam int QWIDTH = qbt_pkg::CTL_BITS + qbt_pkg::NUM_COORDS * COORD_BITS;

    logic                                               push;
    qbt_pkg::cmd_ctl_t                                  push_ctl;
    logic [qbt_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]     push_coords;
    logic                                               q_full;
    logic                                               q_empty;
    logic                                               q_pop;
    logic [QWIDTH-1:0]                                  q_head;
    qbt_pkg::cmd_ctl_t                                  head_ctl;
    logic [qbt_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]     head_coords;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    // front end
    qbt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (point.valid),
        .in_ready    (point.ready),
        .in_x        (point.point_x),
        .in_y        (point.point_y),
        .in_fin      (point.final_point),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_coords (push_coords),
        .queue_full  (q_full)
    );

    // command queue
    qbt_queue #(
        .WIDTH (QWIDTH),
        .DEPTH (qbt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_coords}),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {head_ctl, head_coords} = q_head;

    // back end
    qbt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.segments),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_ctl     (head_ctl),
        .q_coords  (head_coords),
        .out_valid (curve.valid),
        .out_ready (curve.ready),
        .out_x     (curve.curve_x),
        .out_y     (curve.curve_y),
        .out_eoc   (curve.end_of_curve),
        .out_bad   (curve.bad_count)
    );

endmodule

// File: hdl/qbt_checker.sv
// port-level checks on the tessellator output channel
// depends on qbt_pkg and assert_macros.svh; bound to quadratic_bezier_tessellator_unit
`include "assert_macros.svh"

module qbt_checker #(
    parameter int COORD_BITS = qbt_pkg::COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  curve_valid,
    input logic                  curve_ready,
    input logic [COORD_BITS-1:0] curve_x,
    input logic [COORD_BITS-1:0] curve_y,
    input logic                  curve_eoc,
    input logic                  curve_bad
);

    // error word closes the chain and carries zero coordinates
    `QBT_ASSERT(a_bad_word, clk, rst_n, curve_valid && curve_bad |-> curve_eoc && (curve_x == '0) && (curve_y == '0), "bad count word malformed")

    // stalled word holds
    `QBT_ASSERT(a_out_hold, clk, rst_n, curve_valid && !curve_ready |=> curve_valid && $stable(curve_x) && $stable(curve_y) && $stable(curve_eoc) && $stable(curve_bad), "stalled output word changed")

    // no word out of reset
    `QBT_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !curve_valid, "output valid right after reset")

endmodule

bind quadratic_bezier_tessellator_unit qbt_checker #(
    .COORD_BITS (COORD_BITS)
) u_qbt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .curve_valid (curve.valid),
    .curve_ready (curve.ready),
    .curve_x     (curve.curve_x),
    .curve_y     (curve.curve_y),
    .curve_eoc   (curve.end_of_curve),
    .curve_bad   (curve.bad_count)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the quadratic bezier tessellator: chains of control points
// go in, curve point words are predicted in the bench and checked in order
// depends on qbt_pkg, qbt_if and quadratic_bezier_tessellator_unit
module testbench;

    localparam int COORD_BITS   = qbt_pkg::COORD_BITS_DEF;
    localparam int SEG_BITS     = qbt_pkg::SEG_BITS;
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 63 + COORD_BITS + 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_HANDLE,
        PH_SEG_END
    } chain_phase_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   eoc;
        logic   bad;
    } curve_word_t;

    logic clk;
    logic rst_n;

    qbt_point_if #(.COORD_BITS(COORD_BITS)) point_ch ();
    qbt_curve_if #(.COORD_BITS(COORD_BITS)) curve_ch ();
    qbt_cfg_if                              cfg_ch ();

    quadratic_bezier_tessellator_unit #(.COORD_BITS(COORD_BITS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point_ch),
        .curve (curve_ch),
        .cfg   (cfg_ch)
    );

    // bench copy of the block state
    logic [SEG_BITS-1:0] seg_count;
    coord_t              anchor_x, anchor_y, handle_x, handle_y;
    chain_phase_t        chain_phase;
    logic                chain_started;

    curve_word_t pending_curve[$];
    int          error_count;
    int unsigned cycle_count;

    // sender burst control and back-pressure request
    int unsigned burst_left;
    bit          steady_send;
    bit          hold_off_req;

    // clock and reset
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // one curve coordinate: exact rational value, rounded half away from zero, saturated
    function automatic coord_t blend_coord(input coord_t p0, input coord_t p1,
                                           input coord_t p2, input longint n,
                                           input longint j);
        longint u, num, den, q, hi, lo;
        u   = n - j;
        num = u * u * longint'(p0) + 2 * u * j * longint'(p1) + j * j * longint'(p2);
        den = n * n;
        if (num >= 0)
            q = (num + den / 2) / den;
        else
            q = -((-num + den / 2) / den);
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return coord_t'(q);
    endfunction

    function automatic void push_word(input coord_t x, input coord_t y,
                                      input logic eoc, input logic bad);
        curve_word_t w;
        w.x   = x;
        w.y   = y;
        w.eoc = eoc;
        w.bad = bad;
        pending_curve.push_back(w);
    endfunction

    // advance the chain by one accepted point and queue the words it causes
    function automatic void tessellate_point(input coord_t px, input coord_t py,
                                             input logic fin);
        longint n;
        n = (seg_count == 0) ? 1 : longint'(seg_count);
        if (chain_phase == PH_START || chain_phase == PH_HANDLE)
        begin
            if (chain_phase == PH_START)
            begin
                anchor_x = px;
                anchor_y = py;
            end
            else
            begin
                handle_x = px;
                handle_y = py;
            end
            if (fin)
            begin
                // point count below three or even
                push_word('0, '0, 1'b1, 1'b1);
                chain_phase   = PH_START;
                chain_started = 1'b0;
            end
            else
                chain_phase = (chain_phase == PH_START) ? PH_HANDLE : PH_SEG_END;
            return;
        end
        // segment end, with the chain start point ahead of the first segment
        if (!chain_started)
            push_word(anchor_x, anchor_y, 1'b0, 1'b0);
        for (longint j = 1; j <= n; j++)
            push_word(blend_coord(anchor_x, handle_x, px, n, j),
                      blend_coord(anchor_y, handle_y, py, n, j),
                      fin && (j == n), 1'b0);
        anchor_x = px;
        anchor_y = py;
        if (fin)
        begin
            chain_phase   = PH_START;
            chain_started = 1'b0;
        end
        else
        begin
            chain_phase   = PH_HANDLE;
            chain_started = 1'b1;
        end
    endfunction

    // send one point word, with a random gap when the burst runs out and sending is not steady
    task automatic send_point(input coord_t px, input coord_t py, input logic fin);
        int unsigned gap;
        if (burst_left == 0 && !steady_send)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left != 0)
            burst_left--;
        point_ch.valid       <= 1'b1;
        point_ch.point_x     <= px;
        point_ch.point_y     <= py;
        point_ch.final_point <= fin;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        tessellate_point(px, py, fin);
    endtask

    task automatic idle_points();
        point_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_curve.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // segments register write, only once the block has gone quiet
    task automatic write_segments(input logic [SEG_BITS-1:0] value);
        idle_points();
        wait_idle();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.segments <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        seg_count = value;
    endtask

    // mostly full-range values, with the extremes and zero mixed in
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(COORD_BITS-1){1'b0}}};
            1: return {1'b0, {(COORD_BITS-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_chain(input int len);
        for (int i = 0; i < len; i++)
            send_point(pick_coord(), pick_coord(), i == len - 1);
    endtask

    // full-scale points at the reset setting of 32
    task automatic test_extreme_points();
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b1);
    endtask

    // chains that end on a start point or on a handle
    task automatic test_bad_counts();
        send_point(16'sh0123, -16'sh0456, 1'b1);
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b1);
        send_point(-16'sh0001, 16'sh0000, 1'b0);
        send_point(16'sh4000, -16'sh4000, 1'b0);
        send_point(16'sh0000, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh0001, 1'b1);
    endtask

    // zero acting as one, the smallest and the largest setting
    task automatic test_segment_extremes();
        write_segments('0);
        send_chain(3);
        write_segments(6'd1);
        send_chain(5);
        write_segments(6'd63);
        send_point(-16'sh0001, 16'sh0000, 1'b0);
        send_point(16'sh0000, -16'sh0001, 1'b0);
        send_point(16'sh0001, 16'sh0001, 1'b1);
    endtask

    // long receiver hold-off while points keep coming, so the input stalls
    task automatic test_back_pressure();
        write_segments(6'd63);
        steady_send  = 1'b1;
        hold_off_req = 1'b1;
        send_chain(9);
        steady_send = 1'b0;
    endtask

    function automatic logic [SEG_BITS-1:0] pick_segments();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 6'd1;
            2: return 6'd63;
            3: return qbt_pkg::SEG_RESET;
            default: return SEG_BITS'($urandom_range(2, 16));
        endcase
    endfunction

    // random chains, mostly well formed, under changing settings
    task automatic test_random_chains();
        int sent, len;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                write_segments(pick_segments());
            if ($urandom_range(0, 6) == 0)
                len = $urandom_range(0, 1) ? 1 : 2 * $urandom_range(1, 4);
            else
                len = 2 * $urandom_range(1, 4) + 1;
            send_chain(len);
            sent += len;
        end
    endtask

    // receiver: ready pattern changing from stretch to stretch, plus long hold-offs
    initial
    begin : receiver
        int unsigned stretch, mode, tick;
        stretch = 0;
        mode    = 0;
        tick    = 0;
        curve_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                curve_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 200);
                end
                stretch--;
                tick++;
                case (mode)
                    0: curve_ch.ready <= 1'b1;
                    1: curve_ch.ready <= 1'($urandom_range(0, 1));
                    2: curve_ch.ready <= (tick % 5) > 1;
                    default: curve_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: curve word %s mismatch: expected %0d, actual %0d",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    // compare each accepted curve word with the oldest prediction
    always @(posedge clk)
    begin : check_curve
        curve_word_t want;
        if (rst_n && curve_ch.valid && curve_ch.ready)
        begin
            if (pending_curve.size() == 0)
            begin
                $display("%0t: unexpected curve word: expected none, actual x=%0d y=%0d",
                         $time, curve_ch.curve_x, curve_ch.curve_y);
                error_count++;
            end
            else
            begin
                want = pending_curve.pop_front();
                check_field("curve_x", want.x, curve_ch.curve_x);
                check_field("curve_y", want.y, curve_ch.curve_y);
                check_field("end_of_curve", want.eoc, curve_ch.end_of_curve);
                check_field("bad_count", want.bad, curve_ch.bad_count);
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run limit reached with %0d words outstanding",
                 $time, pending_curve.size());
        $display("FAILURE");
        $finish;
    end

    // test sequence
    initial
    begin
        point_ch.valid       <= 1'b0;
        point_ch.point_x     <= '0;
        point_ch.point_y     <= '0;
        point_ch.final_point <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.segments      <= '0;
        seg_count     = qbt_pkg::SEG_RESET;
        anchor_x      = '0;
        anchor_y      = '0;
        handle_x      = '0;
        handle_y      = '0;
        chain_phase   = PH_START;
        chain_started = 1'b0;
        error_count   = 0;
        burst_left    = 0;
        steady_send   = 1'b0;
        hold_off_req  = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        test_extreme_points();
        test_bad_counts();
        test_segment_extremes();
        test_back_pressure();
        test_random_chains();

        idle_points();
        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/qbt_pkg.sv
hdl/qbt_if.sv
hdl/qbt_front.sv
hdl/qbt_queue.sv
hdl/qbt_div.sv
hdl/qbt_back.sv
hdl/quadratic_bezier_tessellator_unit.sv
hdl/qbt_checker.sv
tb/testbench.sv
